### hdl/ffpa_pkg.sv
package ffpa_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_WIDTH  = 16;
    localparam int OWNER_WIDTH = 8;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Configuration register map
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_SIZE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_SIZE = CFG_IDX_W'(1);

    localparam logic [ADDR_WIDTH-1:0] RESET_MEMORY_SIZE   = ADDR_WIDTH'(3000);
    localparam logic [ADDR_WIDTH-1:0] RESET_RESERVED_SIZE = ADDR_WIDTH'(300);

    // Request commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NO_OWNER = 2'd3
    } t_status;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0]  start;
        logic [ADDR_WIDTH-1:0]  length;
        logic [OWNER_WIDTH-1:0] owner;
        logic                   free;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           entry;
    } t_tbl_wr;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] a;
        logic [ADDR_WIDTH-1:0] b;
        logic                  sub;
    } t_alu_req;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] sum;
        logic                  carry;
        logic                  zero;
    } t_alu_res;

endpackage

### hdl/ffpa_if.sv
interface ffpa_req_if import ffpa_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   command;
    logic [OWNER_WIDTH-1:0] owner_id;
    logic [ADDR_WIDTH-1:0]  request_size;

    modport source (output valid, command, owner_id, request_size, input ready);
    modport sink   (input valid, command, owner_id, request_size, output ready);
endinterface

interface ffpa_rsp_if import ffpa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_status               status;
    logic [ADDR_WIDTH-1:0] start_address;

    modport source (output valid, status, start_address, input ready);
    modport sink   (input valid, status, start_address, output ready);
endinterface

interface ffpa_cfg_if import ffpa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [ADDR_WIDTH-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/ffpa_alu.sv
// Shared add/subtract unit; carry high on subtract means a >= b.
module ffpa_alu import ffpa_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_res o_res
);

    logic [ADDR_WIDTH-1:0] w_b;
    logic [ADDR_WIDTH:0]   w_full;

    assign w_b    = i_req.sub ? ~i_req.b : i_req.b;
    assign w_full = {1'b0, i_req.a} + {1'b0, w_b} + {{ADDR_WIDTH{1'b0}}, i_req.sub};

    assign o_res.sum   = w_full[ADDR_WIDTH-1:0];
    assign o_res.carry = w_full[ADDR_WIDTH];
    assign o_res.zero  = (w_full[ADDR_WIDTH-1:0] == '0);

endmodule

### hdl/ffpa_table.sv
// Partition table: one write and one read per cycle.
module ffpa_table import ffpa_pkg::*; (
    input  logic             i_clk,
    input  t_tbl_wr          i_wr,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_entry
);

    t_entry r_mem [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
    end

    assign o_rd_entry = r_mem[i_rd_addr];

endmodule

### hdl/first_fit_partition_allocator.sv
// First-fit partition allocator. The block holds an address-ordered table of
// up to TABLE_DEPTH partitions (start, length, owner, free mark). An allocate
// request takes the lowest free partition that is large enough: an exact fit
// is retagged, a larger one is split with the owned part first. A free request
// releases the owner's lowest partition and merges it with free neighbors.
// Every request gives exactly one result (status and start address, address
// zero on failure). One request at a time is in work; the input is not ready
// until its result is in the output register, which may still be waiting while
// the next request is taken. A sequencer touches one table entry per cycle
// through a single shared adder: allocate scans for the first fit and, on a
// split, shifts the entries above it up and writes the owned part; free scans
// for the owner, merges with free neighbors and closes the gap. A write to
// either configuration register rebuilds the reset layout, system partition
// then free remainder, as does reset itself; no request is taken meanwhile.
module first_fit_partition_allocator import ffpa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffpa_req_if.sink    i_in,
    ffpa_rsp_if.source  o_out,
    ffpa_cfg_if.sink    i_cfg
);

    typedef enum logic [3:0] {
        S_INIT0,
        S_INIT1,
        S_IDLE,
        S_A_SCAN,
        S_A_SHIFT,
        S_A_OWN,
        S_F_SCAN,
        S_F_UP,
        S_F_DN,
        S_F_RM,
        S_RESP
    } t_state;

    t_state                 r_state, n_state;
    logic [ADDR_WIDTH-1:0]  r_memory, n_memory;
    logic [ADDR_WIDTH-1:0]  r_reserved, n_reserved;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_ptr, n_ptr;
    logic [CNT_W-1:0]       r_found, n_found;
    logic                   r_cmd, n_cmd;
    logic [OWNER_WIDTH-1:0] r_owner, n_owner;
    logic [ADDR_WIDTH-1:0]  r_size, n_size;
    t_entry                 r_ent, n_ent;
    logic [ADDR_WIDTH-1:0]  r_len, n_len;
    logic                   r_up, n_up;
    logic [1:0]             r_k, n_k;
    t_status                r_status, n_status;
    logic [ADDR_WIDTH-1:0]  r_addr, n_addr;
    logic                   r_out_valid, n_out_valid;
    t_status                r_out_status, n_out_status;
    logic [ADDR_WIDTH-1:0]  r_out_addr, n_out_addr;

    t_tbl_wr          w_wr;
    logic [IDX_W-1:0] w_rd_addr;
    t_entry           w_e;
    t_alu_req         w_alu_req;
    t_alu_res         w_alu;

    logic [CNT_W-1:0] w_ptr_inc, w_ptr_dec, w_found_inc, w_found_dec, w_ptr_k;

    ffpa_table u_table (
        .i_clk      (i_clk),
        .i_wr       (w_wr),
        .i_rd_addr  (w_rd_addr),
        .o_rd_entry (w_e)
    );

    ffpa_alu u_alu (
        .i_req (w_alu_req),
        .o_res (w_alu)
    );

    assign w_ptr_inc   = r_ptr + CNT_W'(1);
    assign w_ptr_dec   = r_ptr - CNT_W'(1);
    assign w_found_inc = r_found + CNT_W'(1);
    assign w_found_dec = r_found - CNT_W'(1);
    assign w_ptr_k     = r_ptr + CNT_W'(r_k);

    // Handshakes: config has priority in idle; a request is held off while config is valid
    assign i_cfg.ready = (r_state == S_IDLE);
    assign i_in.ready  = (r_state == S_IDLE) && !i_cfg.valid;

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.start_address = r_out_addr;

    always_comb begin
        n_state      = r_state;
        n_memory     = r_memory;
        n_reserved   = r_reserved;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_found      = r_found;
        n_cmd        = r_cmd;
        n_owner      = r_owner;
        n_size       = r_size;
        n_ent        = r_ent;
        n_len        = r_len;
        n_up         = r_up;
        n_k          = r_k;
        n_status     = r_status;
        n_addr       = r_addr;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;

        w_wr          = '0;
        w_rd_addr     = r_ptr[IDX_W-1:0];
        w_alu_req.a   = w_e.length;
        w_alu_req.b   = r_size;
        w_alu_req.sub = 1'b1;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            // Rebuild layout: system partition, then the free remainder
            S_INIT0: begin
                w_wr.en           = 1'b1;
                w_wr.addr         = '0;
                w_wr.entry.start  = '0;
                w_wr.entry.length = r_reserved;
                w_wr.entry.owner  = '0;
                w_wr.entry.free   = 1'b0;
                n_state           = S_INIT1;
            end
            S_INIT1: begin
                w_alu_req.a       = r_memory;
                w_alu_req.b       = r_reserved;
                w_wr.en           = 1'b1;
                w_wr.addr         = IDX_W'(1);
                w_wr.entry.start  = r_reserved;
                w_wr.entry.length = (w_alu.carry && !w_alu.zero) ? w_alu.sum : '0;
                w_wr.entry.owner  = '0;
                w_wr.entry.free   = 1'b1;
                n_count           = CNT_W'(2);
                n_state           = S_IDLE;
            end
            S_IDLE: begin
                if (i_cfg.valid) begin
                    unique case (i_cfg.index)
                        CFG_MEMORY_SIZE:   n_memory   = i_cfg.data;
                        CFG_RESERVED_SIZE: n_reserved = i_cfg.data;
                        default:           n_memory   = r_memory;
                    endcase
                    n_state = S_INIT0;
                end else if (i_in.valid) begin
                    n_cmd   = i_in.command;
                    n_owner = i_in.owner_id;
                    n_size  = i_in.request_size;
                    n_ptr   = '0;
                    n_addr  = '0;
                    if (i_in.command == CMD_ALLOC) begin
                        if (i_in.request_size == '0 || i_in.owner_id == '0) begin
                            n_status = ST_NO_FIT;
                            n_state  = S_RESP;
                        end else begin
                            n_state = S_A_SCAN;
                        end
                    end else begin
                        if (i_in.owner_id == '0) begin
                            n_status = ST_NO_OWNER;
                            n_state  = S_RESP;
                        end else begin
                            n_state = S_F_SCAN;
                        end
                    end
                end
            end
            // First-fit scan: length - size through the shared unit
            S_A_SCAN: begin
                if (r_ptr >= r_count) begin
                    n_status = ST_NO_FIT;
                    n_addr   = '0;
                    n_state  = S_RESP;
                end else if (w_e.free && w_alu.carry) begin
                    if (w_alu.zero) begin
                        w_wr.en          = 1'b1;
                        w_wr.addr        = r_ptr[IDX_W-1:0];
                        w_wr.entry       = w_e;
                        w_wr.entry.owner = r_owner;
                        w_wr.entry.free  = 1'b0;
                        n_status         = ST_OK;
                        n_addr           = w_e.start;
                        n_state          = S_RESP;
                    end else if (r_count == CNT_W'(TABLE_DEPTH)) begin
                        n_status = ST_FULL;
                        n_addr   = '0;
                        n_state  = S_RESP;
                    end else begin
                        n_found = r_ptr;
                        n_ent   = w_e;
                        n_len   = w_alu.sum;
                        n_ptr   = r_count;
                        n_state = S_A_SHIFT;
                    end
                end else begin
                    n_ptr = w_ptr_inc;
                end
            end
            // Open a gap above the split entry, top down
            S_A_SHIFT: begin
                w_alu_req.a   = r_ent.start;
                w_alu_req.b   = r_size;
                w_alu_req.sub = 1'b0;
                w_wr.en       = 1'b1;
                w_wr.addr     = r_ptr[IDX_W-1:0];
                if (r_ptr == w_found_inc) begin
                    w_wr.entry.start  = w_alu.sum;
                    w_wr.entry.length = r_len;
                    w_wr.entry.owner  = '0;
                    w_wr.entry.free   = 1'b1;
                    n_state           = S_A_OWN;
                end else begin
                    w_rd_addr  = w_ptr_dec[IDX_W-1:0];
                    w_wr.entry = w_e;
                    n_ptr      = w_ptr_dec;
                end
            end
            S_A_OWN: begin
                w_wr.en           = 1'b1;
                w_wr.addr         = r_found[IDX_W-1:0];
                w_wr.entry.start  = r_ent.start;
                w_wr.entry.length = r_size;
                w_wr.entry.owner  = r_owner;
                w_wr.entry.free   = 1'b0;
                n_count           = r_count + CNT_W'(1);
                n_status          = ST_OK;
                n_addr            = r_ent.start;
                n_state           = S_RESP;
            end
            S_F_SCAN: begin
                if (r_ptr >= r_count) begin
                    n_status = ST_NO_OWNER;
                    n_addr   = '0;
                    n_state  = S_RESP;
                end else if (!w_e.free && w_e.owner == r_owner) begin
                    n_found = r_ptr;
                    n_ent   = w_e;
                    n_state = S_F_UP;
                end else begin
                    n_ptr = w_ptr_inc;
                end
            end
            // Merge with the neighbor above
            S_F_UP: begin
                w_rd_addr     = w_found_inc[IDX_W-1:0];
                w_alu_req.a   = r_ent.length;
                w_alu_req.b   = w_e.length;
                w_alu_req.sub = 1'b0;
                n_len         = r_ent.length;
                n_up          = 1'b0;
                if (w_found_inc < r_count && w_e.free) begin
                    n_len = w_alu.sum;
                    n_up  = 1'b1;
                end
                n_state = S_F_DN;
            end
            // Merge into the neighbor below, or write the freed entry back
            S_F_DN: begin
                w_rd_addr        = w_found_dec[IDX_W-1:0];
                w_alu_req.a      = w_e.length;
                w_alu_req.b      = r_len;
                w_alu_req.sub    = 1'b0;
                w_wr.en          = 1'b1;
                w_wr.entry.owner = '0;
                w_wr.entry.free  = 1'b1;
                if (r_found != '0 && w_e.free) begin
                    w_wr.addr         = w_found_dec[IDX_W-1:0];
                    w_wr.entry.start  = w_e.start;
                    w_wr.entry.length = w_alu.sum;
                    n_ptr             = r_found;
                    n_k               = {r_up, ~r_up};
                end else begin
                    w_wr.addr         = r_found[IDX_W-1:0];
                    w_wr.entry.start  = r_ent.start;
                    w_wr.entry.length = r_len;
                    n_ptr             = w_found_inc;
                    n_k               = {1'b0, r_up};
                end
                n_status = ST_OK;
                n_addr   = r_ent.start;
                n_state  = S_F_RM;
            end
            // Close the gap left by merged entries, bottom up
            S_F_RM: begin
                w_rd_addr = w_ptr_k[IDX_W-1:0];
                if (r_k == 2'd0 || w_ptr_k >= r_count) begin
                    n_count = r_count - CNT_W'(r_k);
                    n_state = S_RESP;
                end else begin
                    w_wr.en    = 1'b1;
                    w_wr.addr  = r_ptr[IDX_W-1:0];
                    w_wr.entry = w_e;
                    n_ptr      = w_ptr_inc;
                end
            end
            S_RESP: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_addr   = r_addr;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT0;
            r_memory    <= RESET_MEMORY_SIZE;
            r_reserved  <= RESET_RESERVED_SIZE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_memory    <= n_memory;
            r_reserved  <= n_reserved;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_ptr        <= n_ptr;
        r_found      <= n_found;
        r_cmd        <= n_cmd;
        r_owner      <= n_owner;
        r_size       <= n_size;
        r_ent        <= n_ent;
        r_len        <= n_len;
        r_up         <= n_up;
        r_k          <= n_k;
        r_status     <= n_status;
        r_addr       <= n_addr;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
    end

    // Table never empties and never overflows once built
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_count != '0 && r_count <= CNT_W'(TABLE_DEPTH)))
        else $error("partition count out of range");

    // Failed requests report a zero address
    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_addr == '0))
        else $error("nonzero address on failed request");

    // An accepted request keeps the input closed in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request taken while another in work");

    // A free request never answers table full
    a_free_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_cmd == CMD_FREE) |-> (r_status != ST_FULL))
        else $error("table full reported for free");

endmodule

### tb/tb.sv
module tb;
    import ffpa_pkg::*;

    // Settling wait after the last answer: the slowest request plus margin.
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;
    // Length of the long output hold-off in the backpressure test.
    localparam int STALL_CYCLES  = 400;

    // One answer of the allocator: status and start address.
    typedef struct packed {
        t_status               status;
        logic [ADDR_WIDTH-1:0] addr;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ffpa_req_if req_ch();
    ffpa_rsp_if rsp_ch();
    ffpa_cfg_if cfg_ch();

    first_fit_partition_allocator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow partition table. It follows every accepted request and every
    // register write, so that each answer can be worked out up front.
    // ------------------------------------------------------------------
    t_entry                part_tbl [TABLE_DEPTH];
    int                    part_cnt;
    logic [ADDR_WIDTH-1:0] mem_units;
    logic [ADDR_WIDTH-1:0] rsv_units;

    // Answers still owed by the block, oldest first.
    t_answer awaited_answers[$];

    // Test control and bookkeeping.
    bit calm;               // no random idling on either side while set
    int hold_len;           // length of the next output hold-off
    int hold_tag;           // bumped to start a hold-off
    int err_cnt;
    int status_seen[4];
    int n_layouts;
    int n_sent;

    // Reset layout: system partition at 0, everything above it free.
    function automatic void rebuild_table();
        foreach (part_tbl[k])
            part_tbl[k] = '0;
        part_tbl[0].length = rsv_units;
        part_tbl[1].start  = rsv_units;
        part_tbl[1].length = (rsv_units < mem_units) ? mem_units - rsv_units : '0;
        part_tbl[1].free   = 1'b1;
        part_cnt = 2;
    endfunction

    function automatic void drop_entry(input int pos);
        for (int j = pos; j + 1 < part_cnt; j++)
            part_tbl[j] = part_tbl[j + 1];
        part_cnt--;
        part_tbl[part_cnt] = '0;
    endfunction

    // First fit: exact fit is retagged, a larger one is split owned-part-first.
    function automatic t_answer alloc_partition(input logic [OWNER_WIDTH-1:0] who,
                                                input logic [ADDR_WIDTH-1:0] size);
        t_answer ans;
        ans = '{status: ST_NO_FIT, addr: '0};
        if (size == 0 || who == 0)
            return ans;
        for (int i = 0; i < part_cnt; i++) begin
            if (!part_tbl[i].free || part_tbl[i].length < size)
                continue;
            if (part_tbl[i].length == size) begin
                part_tbl[i].free  = 1'b0;
                part_tbl[i].owner = who;
                return '{status: ST_OK, addr: part_tbl[i].start};
            end
            // Only the first fitting partition counts, even with a full table.
            if (part_cnt >= TABLE_DEPTH) begin
                ans.status = ST_FULL;
                return ans;
            end
            for (int j = part_cnt; j > i; j--)
                part_tbl[j] = part_tbl[j - 1];
            part_cnt++;
            part_tbl[i + 1].start  = part_tbl[i].start + size;
            part_tbl[i + 1].length = part_tbl[i].length - size;
            part_tbl[i].length = size;
            part_tbl[i].owner  = who;
            part_tbl[i].free   = 1'b0;
            return '{status: ST_OK, addr: part_tbl[i].start};
        end
        return ans;
    endfunction

    // Release the owner's lowest partition and merge with free neighbors.
    function automatic t_answer release_partition(input logic [OWNER_WIDTH-1:0] who);
        t_answer ans;
        int      hit;
        ans = '{status: ST_NO_OWNER, addr: '0};
        hit = -1;
        if (who == 0)
            return ans;
        for (int i = 0; i < part_cnt; i++) begin
            if (!part_tbl[i].free && part_tbl[i].owner == who) begin
                hit = i;
                break;
            end
        end
        if (hit < 0)
            return ans;
        ans = '{status: ST_OK, addr: part_tbl[hit].start};
        part_tbl[hit].free  = 1'b1;
        part_tbl[hit].owner = '0;
        if (hit + 1 < part_cnt && part_tbl[hit + 1].free) begin
            part_tbl[hit].length = part_tbl[hit].length + part_tbl[hit + 1].length;
            drop_entry(hit + 1);
        end
        if (hit > 0 && part_tbl[hit - 1].free) begin
            part_tbl[hit - 1].length = part_tbl[hit - 1].length + part_tbl[hit].length;
            drop_entry(hit);
        end
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Request side. valid stays high after a transfer; the next call (made
    // in the same time step) either drops it for a gap or presents the next
    // request, so valid gets a single assignment per step.
    // ------------------------------------------------------------------
    task automatic send_req(input logic cmd, input logic [OWNER_WIDTH-1:0] who,
                            input logic [ADDR_WIDTH-1:0] size);
        int gap;
        if (!calm && $urandom_range(99) < 16) begin
            // gap of random length so idling lands on every phase of a request
            gap = $urandom_range(1, 48);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.command      <= cmd;
        req_ch.owner_id     <= who;
        req_ch.request_size <= size;
        do @(posedge i_clk); while (!req_ch.ready);
        if (cmd == CMD_ALLOC)
            awaited_answers.insert(awaited_answers.size(), alloc_partition(who, size));
        else
            awaited_answers.insert(awaited_answers.size(), release_partition(who));
        n_sent++;
    endtask

    // Stop offering and wait until every owed answer has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (awaited_answers.size() != 0)
            @(posedge i_clk);
    endtask

    // Write both registers back to back, with the block idle. valid stays
    // high across the two transfers.
    task automatic set_layout(input logic [ADDR_WIDTH-1:0] mem,
                              input logic [ADDR_WIDTH-1:0] rsv);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_MEMORY_SIZE;
        cfg_ch.data  <= mem;
        do @(posedge i_clk); while (!cfg_ch.ready);
        mem_units = mem;
        rebuild_table();
        cfg_ch.index <= CFG_RESERVED_SIZE;
        cfg_ch.data  <= rsv;
        do @(posedge i_clk); while (!cfg_ch.ready);
        rsv_units = rsv;
        rebuild_table();
        cfg_ch.valid <= 1'b0;
        n_layouts++;
    endtask

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Out of reset (3000 / 300): splits, refusals, merges above and on both sides.
    task automatic test_reset_layout();
        send_req(CMD_ALLOC, 8'd1, 16'd100);
        send_req(CMD_ALLOC, 8'd2, 16'd100);
        send_req(CMD_ALLOC, 8'd3, 16'd100);
        send_req(CMD_ALLOC, 8'd0, 16'd10);      // system id refused
        send_req(CMD_ALLOC, 8'd4, 16'd0);       // zero size
        send_req(CMD_FREE,  8'd0, 16'hffff);    // system id cannot be freed
        send_req(CMD_FREE,  8'd99, 16'd0);      // unknown owner
        send_req(CMD_FREE,  8'd1, 16'd0);       // no free neighbor
        send_req(CMD_FREE,  8'd3, 16'd0);       // merges with free tail
        send_req(CMD_FREE,  8'd2, 16'd0);       // merges both sides
        send_req(CMD_ALLOC, 8'd200, 16'hffff);  // larger than memory
        drain();
    endtask

    // Register extremes, including reserved not below memory.
    task automatic test_register_extremes();
        set_layout(16'hffff, 16'h0000);
        send_req(CMD_ALLOC, 8'd128, 16'hffff);  // whole memory, exact fit at 0
        send_req(CMD_FREE,  8'd128, 16'd0);
        set_layout(16'h0001, 16'hffff);
        send_req(CMD_ALLOC, 8'd1, 16'd1);       // free entry has zero length
        set_layout(16'h0001, 16'h0000);
        send_req(CMD_ALLOC, 8'd255, 16'd1);
        drain();
    endtask

    // Fill all entries, then split refusal, exact fits at full, and several
    // partitions of one owner.
    task automatic test_table_full();
        set_layout(RESET_MEMORY_SIZE, RESET_RESERVED_SIZE);
        for (int k = 1; k <= TABLE_DEPTH - 2; k++)
            send_req(CMD_ALLOC, OWNER_WIDTH'(k), 16'd10);
        send_req(CMD_ALLOC, 8'd20, 16'd5);       // would need a split
        send_req(CMD_ALLOC, 8'd21, 16'd2560);    // exact fit of the tail
        send_req(CMD_FREE,  8'd5, 16'd0);        // hole between owned parts
        send_req(CMD_ALLOC, 8'd22, 16'd5);       // first fit is the hole, full
        send_req(CMD_ALLOC, 8'd22, 16'd10);      // exact fit into the hole
        send_req(CMD_FREE,  8'd3, 16'd0);
        send_req(CMD_FREE,  8'd4, 16'd0);        // merges below
        send_req(CMD_ALLOC, 8'd7, 16'd5);        // owner 7 now holds two parts
        send_req(CMD_FREE,  8'd7, 16'd0);        // lowest one goes
        drain();
    endtask

    // Sender keeps offering while the receiver holds off for a long time.
    task automatic test_output_backpressure();
        set_layout(RESET_MEMORY_SIZE, RESET_RESERVED_SIZE);
        calm = 1'b1;
        hold_len = STALL_CYCLES;
        hold_tag++;
        for (int k = 1; k <= 12; k++)
            send_req(CMD_ALLOC, OWNER_WIDTH'(k), ADDR_WIDTH'(k * 7));
        for (int k = 12; k >= 1; k -= 2)
            send_req(CMD_FREE, OWNER_WIDTH'(k), 16'd0);
        calm = 1'b0;
        drain();
    endtask

    // Mostly well-formed allocate/free traffic against the shadow table,
    // with some refusals and stray requests mixed in.
    task automatic test_random_traffic(input logic [ADDR_WIDTH-1:0] mem,
                                       input logic [ADDR_WIDTH-1:0] rsv,
                                       input int n_req, input bit quiet);
        logic [OWNER_WIDTH-1:0] held[$];
        logic [ADDR_WIDTH-1:0]  holes[$];
        logic [OWNER_WIDTH-1:0] who;
        logic [ADDR_WIDTH-1:0]  sz;
        int                     pick;
        set_layout(mem, rsv);
        calm = quiet;
        repeat (n_req) begin
            held.delete();
            holes.delete();
            for (int k = 0; k < part_cnt; k++) begin
                if (part_tbl[k].free)
                    holes.insert(holes.size(), part_tbl[k].length);
                else if (part_tbl[k].owner != 0)
                    held.insert(held.size(), part_tbl[k].owner);
            end
            who = ($urandom_range(99) < 85) ? OWNER_WIDTH'($urandom_range(1, 15))
                                            : OWNER_WIDTH'($urandom_range(1, 255));
            sz = ADDR_WIDTH'($urandom_range(1, (int'(mem_units) >> 3) + 1));
            pick = $urandom_range(99);
            if (pick < 50) begin
                pick = $urandom_range(99);
                if (pick < 12 && holes.size() != 0)
                    sz = holes[$urandom_range(holes.size() - 1)];   // exact fit
                else if (pick < 22)
                    sz = ADDR_WIDTH'($urandom_range(1, 65535));
                else if (pick < 24)
                    sz = '0;
                send_req(CMD_ALLOC, who, sz);
            end else if (pick < 93) begin
                if (held.size() != 0)
                    who = held[$urandom_range(held.size() - 1)];
                send_req(CMD_FREE, who, ADDR_WIDTH'($urandom_range(0, 65535)));
            end else if (pick < 96) begin
                send_req(CMD_ALLOC, '0, sz);
            end else begin
                send_req(CMD_FREE, OWNER_WIDTH'($urandom_range(0, 255)),
                         ADDR_WIDTH'($urandom_range(0, 65535)));
            end
        end
        calm = 1'b0;
        drain();
    endtask

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    // ready: random idling, high while calm, low during a hold-off, which wins over calm.
    always @(posedge i_clk) begin : rsp_ready_gen
        static int seen_tag = 0;
        static int stall_left = 0;
        if (hold_tag != seen_tag) begin
            seen_tag   = hold_tag;
            stall_left = hold_len;
        end
        if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end else if (calm) begin
            rsp_ch.ready <= 1'b1;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= 16);
        end
    end

    // Each transfer on the response channel is matched to the oldest answer.
    always @(posedge i_clk) begin : answer_check
        t_answer want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            status_seen[rsp_ch.status]++;
            if (awaited_answers.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result, status %0d addr %0d", $time,
                         rsp_ch.status, rsp_ch.start_address);
            end else begin
                want = awaited_answers.pop_front();
                if (rsp_ch.status !== want.status) begin
                    err_cnt++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, rsp_ch.status);
                end
                if (rsp_ch.start_address !== want.addr) begin
                    err_cnt++;
                    $display("%0t: start_address expected %0d actual %0d", $time,
                             want.addr, rsp_ch.start_address);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------
    initial begin
        calm      = 1'b0;
        hold_len  = 0;
        hold_tag  = 0;
        err_cnt   = 0;
        n_layouts = 0;
        n_sent    = 0;
        foreach (status_seen[k])
            status_seen[k] = 0;
        i_rst_n             <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.command      <= CMD_ALLOC;
        req_ch.owner_id     <= '0;
        req_ch.request_size <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_MEMORY_SIZE;
        cfg_ch.data         <= '0;
        mem_units = RESET_MEMORY_SIZE;
        rsv_units = RESET_RESERVED_SIZE;
        rebuild_table();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_layout();
        test_register_extremes();
        test_table_full();
        test_output_backpressure();
        test_random_traffic(RESET_MEMORY_SIZE, RESET_RESERVED_SIZE, 120, 1'b0);
        test_random_traffic(16'hffff, 16'h0000, 120, 1'b1);
        test_random_traffic(16'd400, 16'd40, 130, 1'b0);
        test_random_traffic(16'd1024, 16'd1000, 130, 1'b0);

        // catch any stray result after the last expected one
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d requests over %0d register settings: %0d ok, %0d no fit,",
                 n_sent, n_layouts, status_seen[ST_OK], status_seen[ST_NO_FIT]);
        $display("%0d table full, %0d owner not found; %0d-cycle output stall included",
                 status_seen[ST_FULL], status_seen[ST_NO_OWNER], STALL_CYCLES);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
hdl/ffpa_pkg.sv
hdl/ffpa_if.sv
hdl/ffpa_alu.sv
hdl/ffpa_table.sv
hdl/first_fit_partition_allocator.sv
tb/tb.sv
